// File: hw/rtl/tde_pkg.sv
// ----------------------------------------------------------------------------
// Taylor dispersion evaluator package
// Shared widths, codes, payload words and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tde_pkg;

	localparam int DATA_W        = 32;
	localparam int ACC_W         = 48;
	localparam int MAG_W         = ACC_W + 1;
	localparam int HI_W          = MAG_W - DATA_W;
	localparam int PROD_W        = 2 * DATA_W;
	localparam int FULL_W        = MAG_W + DATA_W;
	localparam int FRAC_W        = 16;
	localparam int Q_W           = FULL_W - FRAC_W;
	localparam int CNT_W         = 3;
	localparam int OP_W          = 2;
	localparam int IDX_W         = 3;
	localparam int MAX_COEFS_DEF = 6;
	localparam int DIV_BITS      = 8;
	localparam int DIV_STEPS     = ACC_W / DIV_BITS;
	localparam int STEP_W        = $clog2(DIV_STEPS);

	localparam logic [OP_W-1:0] OP_PHASE = 2'd0;
	localparam logic [OP_W-1:0] OP_GD    = 2'd1;
	localparam logic [OP_W-1:0] OP_GDD   = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

	localparam logic [IDX_W-1:0] REG_CENTER = 3'd0;
	localparam logic [IDX_W-1:0] REG_COUNT  = 3'd1;
	localparam logic [IDX_W-1:0] REG_COEF0  = 3'd2;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] frequency;
	} sample_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] value;
		logic                    saturated;
	} result_t;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] wdata;
	} cfg_t;

	typedef struct packed {
		logic             load;
		logic             sum;
		logic             use_coef;
		logic             negate;
		logic             mul_lo;
		logic             mul_hi;
		logic             comb;
		logic             div_init;
		logic             div_step;
		logic             div_fix;
		logic             addc;
		logic             emit;
		logic [CNT_W-1:0] idx;
		logic [CNT_W-1:0] divisor;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [CNT_W-1:0] n;
		logic             out_free;
	} sts_t;

endpackage

// File: hw/rtl/tde_chan_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one word of the given payload type per handshake.
// ----------------------------------------------------------------------------
interface tde_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/tde_ctrl.sv
// ----------------------------------------------------------------------------
// Taylor dispersion evaluator controller
// Sequences the Horner loop: accumulate, two-part multiply, digit-serial
// division, and the closing step of the phase and GDD ops.
// ----------------------------------------------------------------------------
module tde_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tde_pkg::sts_t sts,
	output tde_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_START  = 11'b000_0000_0010,
		S_SUM    = 11'b000_0000_0100,
		S_MUL_LO = 11'b000_0000_1000,
		S_MUL_HI = 11'b000_0001_0000,
		S_COMB   = 11'b000_0010_0000,
		S_DINIT  = 11'b000_0100_0000,
		S_DIV    = 11'b000_1000_0000,
		S_FIX    = 11'b001_0000_0000,
		S_ADDC   = 11'b010_0000_0000,
		S_DONE   = 11'b100_0000_0000
	} state_t;

	localparam logic [tde_pkg::STEP_W-1:0] STEP_LAST =
		tde_pkg::STEP_W'(tde_pkg::DIV_STEPS - 1);

	state_t                        state_q, state_d;
	logic [tde_pkg::CNT_W-1:0]     idx_q, idx_d;
	logic                          final_q, final_d;
	logic [tde_pkg::STEP_W-1:0]    step_q, step_d;
	logic [tde_pkg::CNT_W-1:0]     divisor;
	logic                          last;
	state_t                        nxt_state;
	logic [tde_pkg::CNT_W-1:0]     nxt_idx;
	logic                          nxt_final;

	always_comb begin
		unique case (sts.op)
			tde_pkg::OP_PHASE: divisor = idx_q + 3'd2;
			tde_pkg::OP_GD:    divisor = idx_q + 3'd1;
			default:           divisor = idx_q;
		endcase
		if (sts.op == tde_pkg::OP_GDD) begin
			last = (idx_q == 3'd1);
		end else begin
			last = (idx_q == '0);
		end
	end

	// Where to go once one Horner step has finished.
	always_comb begin
		nxt_state = S_SUM;
		nxt_idx   = idx_q;
		nxt_final = final_q;
		if (last) begin
			unique case (sts.op)
				tde_pkg::OP_PHASE: nxt_final = 1'b1;
				tde_pkg::OP_GD:    nxt_state = S_DONE;
				default:           nxt_state = S_ADDC;
			endcase
		end else begin
			nxt_idx = idx_q - 3'd1;
		end
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		final_d     = final_q;
		step_d      = step_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.idx     = idx_q;
		cmd.divisor = divisor;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				if (sts.n == '0 || sts.op == tde_pkg::OP_NONE) begin
					state_d = S_DONE;
				end else begin
					idx_d   = sts.n - 3'd1;
					final_d = 1'b0;
					if (sts.op == tde_pkg::OP_GDD && sts.n == 3'd1) begin
						state_d = S_ADDC;
					end else begin
						state_d = S_SUM;
					end
				end
			end
			S_SUM: begin
				cmd.sum      = 1'b1;
				cmd.use_coef = !final_q;
				cmd.negate   = final_q;
				state_d      = S_MUL_LO;
			end
			S_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = S_MUL_HI;
			end
			S_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_COMB;
			end
			S_COMB: begin
				cmd.comb = 1'b1;
				if (final_q) begin
					state_d = S_DONE;
				end else if (divisor == 3'd1) begin
					state_d = nxt_state;
					idx_d   = nxt_idx;
					final_d = nxt_final;
				end else begin
					state_d = S_DINIT;
				end
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				step_d       = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_LAST) begin
					state_d = S_FIX;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_FIX: begin
				cmd.div_fix = 1'b1;
				state_d     = nxt_state;
				idx_d       = nxt_idx;
				final_d     = nxt_final;
			end
			S_ADDC: begin
				cmd.addc = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			final_q <= 1'b0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			final_q <= final_d;
			step_q  <= step_d;
		end
	end

endmodule

// File: hw/rtl/tde_datapath.sv
// ----------------------------------------------------------------------------
// Taylor dispersion evaluator datapath
// Configuration registers, accumulator, shared 32x32 multiplier, saturating
// combine, radix-256 constant divider and the result register.
// ----------------------------------------------------------------------------
module tde_datapath #(
	parameter int MAX_COEFS = tde_pkg::MAX_COEFS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tde_pkg::cmd_t    cmd,
	output tde_pkg::sts_t    sts,
	input  tde_pkg::sample_t sample_data,
	input  logic             cfg_we,
	input  tde_pkg::cfg_t    cfg_data,
	input  logic             result_ready,
	output logic             result_valid,
	output tde_pkg::result_t result_data
);

	localparam int DATA_W = tde_pkg::DATA_W;
	localparam int ACC_W  = tde_pkg::ACC_W;
	localparam int MAG_W  = tde_pkg::MAG_W;
	localparam int HI_W   = tde_pkg::HI_W;
	localparam int PROD_W = tde_pkg::PROD_W;
	localparam int FULL_W = tde_pkg::FULL_W;
	localparam int FRAC_W = tde_pkg::FRAC_W;
	localparam int Q_W    = tde_pkg::Q_W;
	localparam int CNT_W  = tde_pkg::CNT_W;
	localparam int DBITS  = tde_pkg::DIV_BITS;
	localparam int CI_W   = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
	localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_COEFS);

	// Configuration registers.
	logic signed [DATA_W-1:0] center_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [DATA_W-1:0] coef_q [MAX_COEFS];

	// Per-item working state.
	logic [tde_pkg::OP_W-1:0] op_q;
	logic [CNT_W-1:0]         n_q;
	logic [DATA_W-1:0]        xmag_q;
	logic                     xneg_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     sat_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     pneg_q;
	logic [PROD_W-1:0]        plo_q;
	logic [HI_W+DATA_W-1:0]   phi_q;
	logic [ACC_W-1:0]         dmag_q;
	logic [CNT_W-1:0]         drem_q;
	logic                     dneg_q;
	logic                     out_valid_q;
	tde_pkg::result_t         out_q;

	logic signed [DATA_W:0]   x_full;
	logic signed [DATA_W-1:0] coef_sel;
	logic signed [MAG_W-1:0]  a_sum;
	logic [DATA_W-1:0]        mul_a;
	logic [PROD_W-1:0]        mul_p;
	logic [FULL_W-1:0]        full;
	logic [Q_W-1:0]           q;
	logic                     rem_nz;
	logic                     ovf_pos;
	logic                     ovf_neg;
	logic signed [ACC_W-1:0]  comb_res;
	logic                     comb_sat;
	logic signed [MAG_W-1:0]  c_sum;
	logic signed [ACC_W-1:0]  addc_res;
	logic                     addc_sat;
	logic [DBITS-1:0]         qbits;
	logic [CNT_W-1:0]         rem_nx;

	assign x_full = {sample_data.frequency[DATA_W-1], sample_data.frequency}
		- {center_q[DATA_W-1], center_q};

	// Accumulator plus the selected coefficient, then sign and magnitude.
	always_comb begin
		coef_sel = cmd.use_coef ? coef_q[cmd.idx[CI_W-1:0]] : '0;
		a_sum    = {{(MAG_W-ACC_W){acc_q[ACC_W-1]}}, acc_q}
			+ {{(MAG_W-DATA_W){coef_sel[DATA_W-1]}}, coef_sel};
	end

	assign mul_a = cmd.mul_hi ? DATA_W'(mag_q[MAG_W-1:DATA_W]) : mag_q[DATA_W-1:0];
	assign mul_p = mul_a * xmag_q;

	// Rebuild the full product, drop the fraction, round toward minus
	// infinity and clip to the 48-bit range.
	always_comb begin
		full    = {phi_q, {DATA_W{1'b0}}} + {{(FULL_W-PROD_W){1'b0}}, plo_q};
		q       = full[FULL_W-1:FRAC_W];
		rem_nz  = |full[FRAC_W-1:0];
		ovf_pos = |q[Q_W-1:ACC_W-1];
		ovf_neg = (|q[Q_W-1:ACC_W])
			|| (q[ACC_W-1] && ((|q[ACC_W-2:0]) || rem_nz));
		if (pneg_q) begin
			comb_sat = ovf_neg;
			comb_res = ovf_neg ? tde_pkg::ACC_MIN
				: ACC_W'(~q[ACC_W-1:0] + {{(ACC_W-1){1'b0}}, !rem_nz});
		end else begin
			comb_sat = ovf_pos;
			comb_res = ovf_pos ? tde_pkg::ACC_MAX : ACC_W'(q[ACC_W-1:0]);
		end
	end

	always_comb begin
		c_sum = {{(MAG_W-ACC_W){acc_q[ACC_W-1]}}, acc_q}
			+ {{(MAG_W-DATA_W){coef_q[0][DATA_W-1]}}, coef_q[0]};
		addc_sat = (c_sum[MAG_W-1] != c_sum[ACC_W-1]);
		if (addc_sat) begin
			addc_res = c_sum[MAG_W-1] ? tde_pkg::ACC_MIN : tde_pkg::ACC_MAX;
		end else begin
			addc_res = c_sum[ACC_W-1:0];
		end
	end

	// One radix-256 digit of restoring division by a divisor of at most 7.
	always_comb begin
		logic [CNT_W:0] r4;
		logic [CNT_W-1:0] r;
		r     = drem_q;
		qbits = '0;
		for (int b = 0; b < DBITS; b++) begin
			r4 = {r, dmag_q[ACC_W-1-b]};
			if (r4 >= {1'b0, cmd.divisor}) begin
				r4               = r4 - {1'b0, cmd.divisor};
				qbits[DBITS-1-b] = 1'b1;
			end
			r = r4[CNT_W-1:0];
		end
		rem_nx = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			count_q  <= '0;
			for (int k = 0; k < MAX_COEFS; k++) begin
				coef_q[k] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_data.index == tde_pkg::REG_CENTER) begin
				center_q <= cfg_data.wdata;
			end
			if (cfg_data.index == tde_pkg::REG_COUNT) begin
				count_q <= cfg_data.wdata[CNT_W-1:0];
			end
			for (int k = 0; k < MAX_COEFS; k++) begin
				if (cfg_data.index == tde_pkg::IDX_W'(tde_pkg::REG_COEF0 + k)) begin
					coef_q[k] <= cfg_data.wdata;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= tde_pkg::OP_NONE;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				op_q <= sample_data.op;
				n_q  <= (count_q > N_MAX) ? N_MAX : count_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xneg_q <= x_full[DATA_W];
			xmag_q <= x_full[DATA_W] ? DATA_W'(-x_full) : DATA_W'(x_full);
			acc_q  <= '0;
			sat_q  <= 1'b0;
		end
		if (cmd.sum) begin
			mag_q  <= a_sum[MAG_W-1] ? MAG_W'(-a_sum) : MAG_W'(a_sum);
			pneg_q <= a_sum[MAG_W-1] ^ xneg_q ^ cmd.negate;
		end
		if (cmd.mul_lo) begin
			plo_q <= mul_p;
		end
		if (cmd.mul_hi) begin
			phi_q <= mul_p[HI_W+DATA_W-1:0];
		end
		if (cmd.comb) begin
			acc_q <= comb_res;
			sat_q <= sat_q | comb_sat;
		end
		if (cmd.div_init) begin
			dneg_q <= acc_q[ACC_W-1];
			dmag_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
			drem_q <= '0;
		end
		if (cmd.div_step) begin
			dmag_q <= {dmag_q[ACC_W-DBITS-1:0], qbits};
			drem_q <= rem_nx;
		end
		if (cmd.div_fix) begin
			acc_q <= dneg_q ? ACC_W'(-dmag_q) : ACC_W'(dmag_q);
		end
		if (cmd.addc) begin
			acc_q <= addc_res;
			sat_q <= sat_q | addc_sat;
		end
		if (cmd.emit) begin
			out_q.value     <= acc_q;
			out_q.saturated <= sat_q;
		end
	end

	assign sts.op       = op_q;
	assign sts.n        = n_q;
	assign sts.out_free = !out_valid_q || result_ready;

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

endmodule

// File: hw/rtl/taylor_dispersion_evaluator_top.sv
// ----------------------------------------------------------------------------
// Taylor dispersion evaluator
// From accept to output register load: each Horner step is an accumulate and
// a two-part multiply, then the radix-256 divider unless it divides by one; the
// phase op adds a closing multiply and GDD a closing add. A zero count or unused
// op goes straight to the load, and the load waits while a result is held.
// One word in flight; the next is taken the cycle after that load.
// Reset clears the configuration.
// ----------------------------------------------------------------------------
module taylor_dispersion_evaluator_top #(
	parameter int MAX_COEFS = tde_pkg::MAX_COEFS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tde_chan_if.sink   sample,
	tde_chan_if.sink   cfg,
	tde_chan_if.source result
);

	tde_pkg::cmd_t cmd;
	tde_pkg::sts_t sts;
	logic          in_ready;

	assign sample.ready = in_ready;
	assign cfg.ready    = 1'b1;

	tde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tde_datapath #(
		.MAX_COEFS (MAX_COEFS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample_data  (sample.data),
		.cfg_we       (cfg.valid && cfg.ready),
		.cfg_data     (cfg.data),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.result_data  (result.data)
	);

endmodule
